// ===== design/brs_pkg.sv =====
// shared types, constants and weight function of the bilinear pixel resampler
package brs_pkg;

  // field widths
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // default store geometry
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // register reset values
  localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = SIZE_W'(256);
  localparam logic [STEP_W-1:0] RST_STEP_X        = STEP_W'(65536);
  localparam logic [STEP_W-1:0] RST_STEP_Y        = STEP_W'(65536);

  // fixed point
  localparam int FRAC_W    = 16;
  localparam int HALF      = 1 << (FRAC_W - 1);
  localparam int MUL_W     = COORD_W + 1 + STEP_W;
  localparam int POS_W     = MUL_W - 1;
  localparam int IPOS_W    = POS_W - FRAC_W;
  localparam int WGT_LOG   = 11;
  localparam int WEIGHT_ONE = 1 << WGT_LOG;
  localparam int WGT_W     = WGT_LOG + 1;
  localparam int WXY_W     = 2 * WGT_LOG + 1;
  localparam int SUM_SHIFT = 2 * WGT_LOG;
  localparam int SUM_W     = CHAN_W + SUM_SHIFT;
  localparam int INV_W     = FRAC_W + 1;
  localparam int WT_W      = FRAC_W + WGT_LOG + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_STEP_X        = 2'd2,
    CFG_STEP_Y        = 2'd3
  } brs_cfg_idx_t;

  typedef enum logic {
    REQ_WRITE   = 1'b0,
    REQ_COMPUTE = 1'b1
  } brs_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOC,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_FIN,
    S_OUT
  } brs_state_t;

  // w0 = round((1 - f) * WEIGHT_ONE), ties up
  function automatic logic [WGT_W-1:0] weight0(input logic [FRAC_W-1:0] frac);
    logic [INV_W-1:0] inv;
    logic [WT_W-1:0]  t;
    inv = INV_W'(1 << FRAC_W) - {1'b0, frac};
    t   = WT_W'(inv) * WT_W'(WEIGHT_ONE) + WT_W'(HALF);
    return t[WT_W-1:FRAC_W];
  endfunction

endpackage

// ===== design/brs_in_if.sv =====
// input channel of the resampler: pixel writes and compute requests
interface brs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [brs_pkg::COORD_W-1:0]    column;
  logic [brs_pkg::COORD_W-1:0]    line;
  logic [brs_pkg::CHAN_W-1:0]     in_blue;
  logic [brs_pkg::CHAN_W-1:0]     in_green;
  logic [brs_pkg::CHAN_W-1:0]     in_red;

  modport source (
    output valid, req_type, column, line, in_blue, in_green, in_red,
    input  ready
  );
  modport sink (
    input  valid, req_type, column, line, in_blue, in_green, in_red,
    output ready
  );
endinterface

// ===== design/brs_out_if.sv =====
// result channel of the resampler: interpolated destination pixels
interface brs_out_if;
  logic                       valid;
  logic                       ready;
  logic [brs_pkg::CHAN_W-1:0] out_blue;
  logic [brs_pkg::CHAN_W-1:0] out_green;
  logic [brs_pkg::CHAN_W-1:0] out_red;

  modport source (
    output valid, out_blue, out_green, out_red,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red,
    output ready
  );
endinterface

// ===== design/brs_ram.sv =====
// generic single-port synchronous ram with registered read
module brs_ram #(
  parameter int WIDTH = brs_pkg::PIX_W,
  parameter int DEPTH = brs_pkg::DEF_MAX_WIDTH * brs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/bilinear_pixel_resampler_core.sv =====
// bilinear pixel resampler: source pixel store and per-pixel interpolation sequencer
//
// The block keeps a BGR source image in a single-port pixel store of
// MAX_WIDTH x MAX_HEIGHT entries (address line * MAX_WIDTH + column). A write
// item (req_type 0) stores one pixel and leaves the input ready; writes outside
// the store are dropped and give no result. A compute item (req_type 1) gives
// one destination pixel: its source position (d + 0.5) * step - 0.5 is formed
// in Q20.16, floored, clamped, turned into weight pairs scaled to 2^11, and the
// four neighbours are blended per channel. A compute item holds off the next
// item through a locate state, four serial reads of the single-port store (one
// neighbour per cycle), a state that folds in the last neighbour and one that
// loads the output register once it is free. The result waits in the output
// register while the next items are accepted. The store is not cleared after
// reset: a compute item that reaches a pixel never written gives arbitrary
// channel values. Configuration is to be written by the user through cfg_we /
// cfg_index / cfg_data while the block is idle; the block does not enforce
// this. Sizes outside 2..MAX are saturated when used.
module bilinear_pixel_resampler_core #(
  parameter int MAX_WIDTH  = brs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = brs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [brs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]   cfg_data,
  brs_in_if.sink                           in_ch,
  brs_out_if.source                        out_ch
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = XW + 1;
  localparam int RW    = YW + 1;

  // configuration registers
  logic [brs_pkg::SIZE_W-1:0] source_width_r, source_height_r;
  logic [brs_pkg::STEP_W-1:0] step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= brs_pkg::RST_SOURCE_WIDTH;
      source_height_r <= brs_pkg::RST_SOURCE_HEIGHT;
      step_x_r        <= brs_pkg::RST_STEP_X;
      step_y_r        <= brs_pkg::RST_STEP_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        brs_pkg::CFG_SOURCE_WIDTH:  source_width_r  <= cfg_data[brs_pkg::SIZE_W-1:0];
        brs_pkg::CFG_SOURCE_HEIGHT: source_height_r <= cfg_data[brs_pkg::SIZE_W-1:0];
        brs_pkg::CFG_STEP_X:        step_x_r        <= cfg_data[brs_pkg::STEP_W-1:0];
        brs_pkg::CFG_STEP_Y:        step_y_r        <= cfg_data[brs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and handshake
  brs_pkg::brs_state_t state_r, state_nxt;
  logic in_accept;
  logic is_compute;
  logic out_load;
  logic out_valid_r, out_valid_nxt;
  logic in_ready_int;

  assign in_ready_int = (state_r == brs_pkg::S_IDLE);
  assign in_ch.ready = in_ready_int;
  assign in_accept   = in_ch.valid && in_ready_int;
  assign is_compute  = (in_ch.req_type == brs_pkg::REQ_COMPUTE);
  assign out_load    = (state_r == brs_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brs_pkg::S_IDLE: begin
        if (in_accept && is_compute) begin
          state_nxt = brs_pkg::S_LOC;
        end
      end
      brs_pkg::S_LOC: state_nxt = brs_pkg::S_RD0;
      brs_pkg::S_RD0: state_nxt = brs_pkg::S_RD1;
      brs_pkg::S_RD1: state_nxt = brs_pkg::S_RD2;
      brs_pkg::S_RD2: state_nxt = brs_pkg::S_RD3;
      brs_pkg::S_RD3: state_nxt = brs_pkg::S_FIN;
      brs_pkg::S_FIN: state_nxt = brs_pkg::S_OUT;
      brs_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = brs_pkg::S_IDLE;
        end
      end
      default: state_nxt = brs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position products, (2d + 1) * step, taken at acceptance
  logic [brs_pkg::MUL_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (in_accept && is_compute) begin
      px_r <= brs_pkg::MUL_W'({in_ch.column, 1'b1}) * brs_pkg::MUL_W'(step_x_r);
      py_r <= brs_pkg::MUL_W'({in_ch.line, 1'b1}) * brs_pkg::MUL_W'(step_y_r);
    end
  end

  // locate: floor, clamp and weights
  logic [CW-1:0]                  w_eff;
  logic [RW-1:0]                  h_eff;
  logic [brs_pkg::POS_W-1:0]      ux, uy;
  logic [brs_pkg::IPOS_W-1:0]     uix, uiy;
  logic [XW-1:0]                  sx_nxt;
  logic [YW-1:0]                  sy_nxt;
  logic [brs_pkg::FRAC_W-1:0]     fx_nxt, fy_nxt;

  always_comb begin
    // saturate sizes in use to 2..MAX
    if (source_width_r < brs_pkg::SIZE_W'(2)) begin
      w_eff = CW'(2);
    end else if (int'(source_width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(source_width_r);
    end
    if (source_height_r < brs_pkg::SIZE_W'(2)) begin
      h_eff = RW'(2);
    end else if (int'(source_height_r) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(source_height_r);
    end

    // drop the half lsb, add one pixel so the floor stays non-negative
    ux  = px_r[brs_pkg::MUL_W-1:1] + brs_pkg::POS_W'(brs_pkg::HALF);
    uy  = py_r[brs_pkg::MUL_W-1:1] + brs_pkg::POS_W'(brs_pkg::HALF);
    uix = ux[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
    uiy = uy[brs_pkg::POS_W-1:brs_pkg::FRAC_W];

    // x: left of the image or at/past the last column clamps and clears fraction
    if (uix == '0) begin
      sx_nxt = '0;
      fx_nxt = '0;
    end else if (uix >= brs_pkg::IPOS_W'(w_eff)) begin
      sx_nxt = XW'(w_eff - CW'(2));
      fx_nxt = '0;
    end else begin
      sx_nxt = XW'(uix - 1'b1);
      fx_nxt = ux[brs_pkg::FRAC_W-1:0];
    end

    // y: index clamped, fraction kept
    fy_nxt = uy[brs_pkg::FRAC_W-1:0];
    if (uiy == '0) begin
      sy_nxt = '0;
    end else if (uiy >= brs_pkg::IPOS_W'(h_eff)) begin
      sy_nxt = YW'(h_eff - RW'(2));
    end else begin
      sy_nxt = YW'(uiy - 1'b1);
    end
  end

  logic [XW-1:0]                sx_r;
  logic [YW-1:0]                sy_r;
  logic [brs_pkg::WGT_W-1:0]    wx0_r, wx1_r, wy0_r, wy1_r;
  logic [brs_pkg::WGT_W-1:0]    wx0_nxt, wy0_nxt;

  assign wx0_nxt = brs_pkg::weight0(fx_nxt);
  assign wy0_nxt = brs_pkg::weight0(fy_nxt);

  always_ff @(posedge clk) begin
    if (state_r == brs_pkg::S_LOC) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      wx0_r <= wx0_nxt;
      wx1_r <= brs_pkg::WGT_W'(brs_pkg::WEIGHT_ONE) - wx0_nxt;
      wy0_r <= wy0_nxt;
      wy1_r <= brs_pkg::WGT_W'(brs_pkg::WEIGHT_ONE) - wy0_nxt;
    end
  end

  // combined weights, one per neighbour
  logic [brs_pkg::WXY_W-1:0] wxy00_r, wxy01_r, wxy10_r, wxy11_r;

  always_ff @(posedge clk) begin
    if (state_r == brs_pkg::S_RD0) begin
      wxy00_r <= brs_pkg::WXY_W'(wx0_r) * brs_pkg::WXY_W'(wy0_r);
      wxy01_r <= brs_pkg::WXY_W'(wx1_r) * brs_pkg::WXY_W'(wy0_r);
      wxy10_r <= brs_pkg::WXY_W'(wx0_r) * brs_pkg::WXY_W'(wy1_r);
      wxy11_r <= brs_pkg::WXY_W'(wx1_r) * brs_pkg::WXY_W'(wy1_r);
    end
  end

  // pixel store port: writes from idle, neighbour reads from the read states
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [brs_pkg::PIX_W-1:0] ram_wdata;
  logic [brs_pkg::PIX_W-1:0] ram_rdata;
  logic                      wr_in_range;
  logic [AW-1:0]             wr_addr;
  logic [XW-1:0]             rd_col;
  logic [YW-1:0]             rd_row;
  logic [AW-1:0]             rd_addr;

  always_comb begin
    wr_in_range = ({1'b0, in_ch.column} < (brs_pkg::COORD_W + 1)'(MAX_WIDTH))
               && ({1'b0, in_ch.line} < (brs_pkg::COORD_W + 1)'(MAX_HEIGHT));
    wr_addr     = AW'(in_ch.line[YW-1:0]) * AW'(MAX_WIDTH) + AW'(in_ch.column[XW-1:0]);
    ram_we      = in_accept && !is_compute && wr_in_range;
    ram_wdata   = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

    // neighbour order: (x, y), (x+1, y), (x, y+1), (x+1, y+1)
    rd_col = sx_r;
    rd_row = sy_r;
    if (state_r == brs_pkg::S_RD1 || state_r == brs_pkg::S_RD3) begin
      rd_col = XW'(sx_r + 1'b1);
    end
    if (state_r == brs_pkg::S_RD2 || state_r == brs_pkg::S_RD3) begin
      rd_row = YW'(sy_r + 1'b1);
    end
    rd_addr = AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col);

    case (state_r)
      brs_pkg::S_RD0,
      brs_pkg::S_RD1,
      brs_pkg::S_RD2,
      brs_pkg::S_RD3: ram_addr = rd_addr;
      default:        ram_addr = wr_addr;
    endcase
  end

  brs_ram #(
    .WIDTH (brs_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // per-channel accumulation, one neighbour per cycle as read data returns
  logic [brs_pkg::WXY_W-1:0] cur_wxy;
  logic [brs_pkg::SUM_W-1:0] acc_r   [3];
  logic [brs_pkg::SUM_W-1:0] acc_nxt [3];
  logic [brs_pkg::SUM_W-1:0] term    [3];

  always_comb begin
    case (state_r)
      brs_pkg::S_RD2: cur_wxy = wxy01_r;
      brs_pkg::S_RD3: cur_wxy = wxy10_r;
      brs_pkg::S_FIN: cur_wxy = wxy11_r;
      default:        cur_wxy = wxy00_r;
    endcase
    for (int k = 0; k < 3; k++) begin
      term[k] = brs_pkg::SUM_W'(ram_rdata[k*brs_pkg::CHAN_W +: brs_pkg::CHAN_W])
              * brs_pkg::SUM_W'(cur_wxy);
      case (state_r)
        brs_pkg::S_RD1: acc_nxt[k] = term[k];
        brs_pkg::S_RD2,
        brs_pkg::S_RD3,
        brs_pkg::S_FIN: acc_nxt[k] = acc_r[k] + term[k];
        default:        acc_nxt[k] = acc_r[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      acc_r[k] <= acc_nxt[k];
    end
  end

  // output register, decoupled from the input side
  logic [brs_pkg::CHAN_W-1:0] out_blue_r, out_green_r, out_red_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // weights sum to one, so the shifted sum never exceeds a channel
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blue_r  <= acc_r[0][brs_pkg::SUM_SHIFT +: brs_pkg::CHAN_W];
      out_green_r <= acc_r[1][brs_pkg::SUM_SHIFT +: brs_pkg::CHAN_W];
      out_red_r   <= acc_r[2][brs_pkg::SUM_SHIFT +: brs_pkg::CHAN_W];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_blue  = out_blue_r;
  assign out_ch.out_green = out_green_r;
  assign out_ch.out_red   = out_red_r;

endmodule

// ===== design/brs_checker.sv =====
// port-level assertions for the resampler and their bind to the top level
module brs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_req_type,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brs_pkg::CHAN_W-1:0] out_blue,
  input logic [brs_pkg::CHAN_W-1:0] out_green,
  input logic [brs_pkg::CHAN_W-1:0] out_red
);

  // a result waiting on the sink stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its channels
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_blue) && $stable(out_green) && $stable(out_red))
    else $error("stalled result changed");

  // a compute item occupies the sequencer
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == brs_pkg::REQ_COMPUTE) |=> !in_ready)
    else $error("input taken while a compute item is in flight");

  // a pixel write leaves the input ready
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == brs_pkg::REQ_WRITE) |=> in_ready)
    else $error("pixel write stalled the input");

  // a new result only comes out of a busy sequencer
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a compute item");

endmodule

bind bilinear_pixel_resampler_core brs_checker u_brs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_blue    (out_ch.out_blue),
  .out_green   (out_ch.out_green),
  .out_red     (out_ch.out_red)
);
